[hw/rtl/arlc_pkg.sv]
package arlc_pkg;

  localparam int unsigned AlphaSize  = 26;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned KeyWidth   = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned ModeWidth  = 2;

  localparam logic [CharWidth-1:0] UpperA = 8'd65;
  localparam logic [CharWidth-1:0] UpperZ = 8'd90;
  localparam logic [CharWidth-1:0] LowerA = 8'd97;
  localparam logic [CharWidth-1:0] LowerZ = 8'd122;
  localparam logic [CharWidth-1:0] CaseBit = 8'd32;

  // floor(p / 26) is at most one short for p below 1024 with this reciprocal
  localparam logic [6:0] RecipMul   = 7'd78;
  localparam int unsigned RecipShift = 11;

  typedef enum logic [ModeWidth-1:0] {
    MODE_CAESAR = 2'd0,
    MODE_AFFINE = 2'd1,
    MODE_RECUR  = 2'd2
  } cipher_mode_e;

  typedef enum logic {
    DIR_ENC = 1'b0,
    DIR_DEC = 1'b1
  } direction_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 3'd0,
    CFG_DIR    = 3'd1,
    CFG_MULT1  = 3'd2,
    CFG_MULT2  = 3'd3,
    CFG_SHIFT1 = 3'd4,
    CFG_SHIFT2 = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [CharWidth-1:0] in_char;
    logic                 msg_start;
  } char_in_t;

  typedef struct packed {
    logic [CharWidth-1:0] out_char;
    logic                 key_fault;
  } char_out_t;

  typedef struct packed {
    logic [KeyWidth-1:0] mult_first;
    logic [KeyWidth-1:0] mult_second;
    logic [KeyWidth-1:0] shift_first;
    logic [KeyWidth-1:0] shift_second;
  } key_cfg_t;

  typedef struct packed {
    logic [KeyWidth-1:0] mult;
    logic [KeyWidth-1:0] shift;
  } key_t;

  // value below 52
  function automatic logic [KeyWidth-1:0] mod26_small(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = (v >= 6'(AlphaSize)) ? v - 6'(AlphaSize) : v;
      return r[KeyWidth-1:0];
    end
  endfunction

  // value below 1024: reciprocal estimate, then one correction
  function automatic logic [KeyWidth-1:0] mod26_wide(input logic [9:0] v);
    logic [16:0] prod;
    logic [5:0]  q;
    logic [9:0]  qm;
    logic [9:0]  r;
    begin
      prod = 17'(v) * 17'(RecipMul);
      q    = prod[RecipShift +: 6];
      qm   = 10'(q) * 10'(AlphaSize);
      r    = v - qm;
      return mod26_small(r[5:0]);
    end
  endfunction

  function automatic logic [KeyWidth-1:0] unit_inverse(input logic [KeyWidth-1:0] a);
    logic [KeyWidth-1:0] inv;
    begin
      unique case (a)
        5'd1:    inv = 5'd1;
        5'd3:    inv = 5'd9;
        5'd5:    inv = 5'd21;
        5'd7:    inv = 5'd15;
        5'd9:    inv = 5'd3;
        5'd11:   inv = 5'd19;
        5'd15:   inv = 5'd7;
        5'd17:   inv = 5'd23;
        5'd19:   inv = 5'd11;
        5'd21:   inv = 5'd5;
        5'd23:   inv = 5'd17;
        5'd25:   inv = 5'd25;
        default: inv = 5'd0;
      endcase
      return inv;
    end
  endfunction

endpackage

[hw/rtl/arlc_keyseq.sv]
module arlc_keyseq
  import arlc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  logic     restart_i,
  input  key_cfg_t key_cfg_i,
  output key_t     key_o
);

  logic [KeyWidth-1:0] older_mult_q, newer_mult_q, older_shift_q, newer_shift_q;
  logic [1:0]          pos_q, pos_d;
  logic [1:0]          pos_eff;
  logic [9:0]          mult_prod;
  logic [5:0]          shift_sum;
  key_t                key;

  always_comb begin
    pos_eff   = restart_i ? 2'd0 : pos_q;
    mult_prod = 10'(older_mult_q) * 10'(newer_mult_q);
    shift_sum = 6'(older_shift_q) + 6'(newer_shift_q);
    unique case (pos_eff)
      2'd0: begin
        key.mult  = mod26_small(6'(key_cfg_i.mult_first));
        key.shift = mod26_small(6'(key_cfg_i.shift_first));
      end
      2'd1: begin
        key.mult  = mod26_small(6'(key_cfg_i.mult_second));
        key.shift = mod26_small(6'(key_cfg_i.shift_second));
      end
      default: begin
        key.mult  = mod26_wide(mult_prod);
        key.shift = mod26_small(shift_sum);
      end
    endcase
    // count up and hold at two
    pos_d = (pos_eff == 2'd2) ? pos_eff : pos_eff + 2'd1;
  end

  assign key_o = key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_mult_q  <= 5'd1;
      newer_mult_q  <= 5'd1;
      older_shift_q <= '0;
      newer_shift_q <= '0;
      pos_q         <= '0;
    end else if (advance_i) begin
      older_mult_q  <= newer_mult_q;
      newer_mult_q  <= key.mult;
      older_shift_q <= newer_shift_q;
      newer_shift_q <= key.shift;
      pos_q         <= pos_d;
    end
  end

endmodule

[hw/rtl/affine_recurrent_letter_cipher.sv]
// A character is accepted into the stage 1 register (key stage), then passes
// through the letter transform stage into the output register, where its result
// is offered and leaves while out_stall_i is low.
// Throughput: one character per cycle while the output is not stalled.
// Reset (asynchronous, active low): pipeline emptied, key sequence back to
// position 0 with multipliers 1 and shifts 0, registers to Caesar encipher
// with multipliers 1 and shifts 0.
module affine_recurrent_letter_cipher
  import arlc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  char_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output char_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cipher_mode_e        mode_q;
  direction_e          dir_q;
  key_cfg_t            key_cfg_q;

  logic                in_acc, out_ready, s1_ready;
  key_t                rec_key;

  logic                s1_valid_q;
  logic [CharWidth-1:0] s1_char_q, s1_char_d;
  logic [KeyWidth-1:0] s1_a_q, s1_a_d, s1_b_q, s1_b_d;
  logic                s1_use_mult_q, s1_use_mult_d;

  logic                out_valid_q;
  char_out_t           out_data_q, out_data_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q                 <= MODE_CAESAR;
      dir_q                  <= DIR_ENC;
      key_cfg_q.mult_first   <= 5'd1;
      key_cfg_q.mult_second  <= 5'd1;
      key_cfg_q.shift_first  <= '0;
      key_cfg_q.shift_second <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q <= cipher_mode_e'(cfg_data_i[ModeWidth-1:0]);
        CFG_DIR:    dir_q  <= direction_e'(cfg_data_i[0]);
        CFG_MULT1:  key_cfg_q.mult_first   <= cfg_data_i;
        CFG_MULT2:  key_cfg_q.mult_second  <= cfg_data_i;
        CFG_SHIFT1: key_cfg_q.shift_first  <= cfg_data_i;
        CFG_SHIFT2: key_cfg_q.shift_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  arlc_keyseq u_keyseq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_acc),
    .restart_i (in_data_i.msg_start),
    .key_cfg_i (key_cfg_q),
    .key_o     (rec_key)
  );

  // stage 1: fold case, pick the key pair for the mode
  always_comb begin
    s1_char_d = in_data_i.in_char;
    if (in_data_i.in_char >= UpperA && in_data_i.in_char <= UpperZ) begin
      s1_char_d = in_data_i.in_char + CaseBit;
    end
    unique case (mode_q)
      MODE_CAESAR: begin
        s1_a_d        = 5'd1;
        s1_b_d        = mod26_small(6'(key_cfg_q.shift_first));
        s1_use_mult_d = 1'b0;
      end
      MODE_AFFINE: begin
        s1_a_d        = mod26_small(6'(key_cfg_q.mult_first));
        s1_b_d        = mod26_small(6'(key_cfg_q.shift_first));
        s1_use_mult_d = 1'b1;
      end
      MODE_RECUR: begin
        s1_a_d        = rec_key.mult;
        s1_b_d        = rec_key.shift;
        s1_use_mult_d = 1'b1;
      end
      default: begin
        // identity map: letters come through folded
        s1_a_d        = 5'd1;
        s1_b_d        = 5'd0;
        s1_use_mult_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q     <= s1_char_d;
      s1_a_q        <= s1_a_d;
      s1_b_q        <= s1_b_d;
      s1_use_mult_q <= s1_use_mult_d;
    end
  end

  // stage 2: letter transform
  logic                is_letter;
  logic [KeyWidth-1:0] x, inv, diff, y;
  logic [9:0]          enc_sum, dec_prod;

  always_comb begin
    is_letter = (s1_char_q >= LowerA) && (s1_char_q <= LowerZ);
    x         = KeyWidth'(s1_char_q - LowerA);
    inv       = unit_inverse(s1_a_q);
    diff      = (x >= s1_b_q) ? x - s1_b_q : KeyWidth'(6'(x) + 6'(AlphaSize) - 6'(s1_b_q));
    enc_sum   = 10'(s1_a_q) * 10'(x) + 10'(s1_b_q);
    dec_prod  = 10'(inv) * 10'(diff);
    y         = (dir_q == DIR_ENC) ? mod26_wide(enc_sum) : mod26_wide(dec_prod);
    out_data_d.out_char  = is_letter ? LowerA + CharWidth'(y) : s1_char_q;
    out_data_d.key_fault = s1_use_mult_q && (inv == 5'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  a_s1_held_while_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_ready) |=> s1_valid_q)
    else $error("stage 1 request lost while output blocked");

  a_no_upper_case_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.out_char >= UpperA && out_data_o.out_char <= UpperZ))
    else $error("upper-case letter left unfolded");

endmodule
